// File: sv/gmc_pkg.sv
// gmc_pkg: shared types and constants of the gate motion controller.
// Used by gmc_div, gmc_dp, gmc_ctrl and gate_motion_controller.
`timescale 1ns / 1ps

package gmc_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DUTY_W    = 8;
  localparam int MS_W      = 16;
  localparam int DIV_W     = DUTY_W + MS_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_UP      = 2'd1,
    ST_DOWN    = 2'd2,
    ST_TRIPPED = 2'd3
  } motion_state_t;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_RESET    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_JOG_UP   = 3'd3;
  localparam logic [2:0] CMD_JOG_DOWN = 3'd4;
  localparam logic [2:0] CMD_OPEN     = 3'd5;
  localparam logic [2:0] CMD_CLOSE    = 3'd6;

  localparam logic [1:0] TONE_NONE   = 2'd0;
  localparam logic [1:0] TONE_TICK   = 2'd1;
  localparam logic [1:0] TONE_ARRIVE = 2'd2;
  localparam logic [1:0] TONE_PINCH  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_RUN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMED_TRAVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADMAN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JOG_MAX     = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_CTRL,
    S_RAMP,
    S_DIV,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic do_cmd;
    logic do_ctrl;
    logic div_start;
    logic set_duty;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic ramp;
    logic div_done;
  } dp_stat_t;

endpackage

// File: sv/gmc_div.sv
// gmc_div: restoring divider, one quotient bit per cycle.
// Depends on gmc_pkg for widths.
`timescale 1ns / 1ps

module gmc_div
  import gmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [MS_W-1:0]   divisor,
  output logic [DIV_W-1:0]  quotient,
  output logic              done
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [MS_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MS_W:0]        trial;
  logic [MS_W:0]        diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[MS_W-1:0] : trial[MS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: sv/gmc_dp.sv
// gmc_dp: configuration registers, gate state, command and control step, duty ramp.
// Depends on gmc_pkg and gmc_div; driven by gmc_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module gmc_dp
  import gmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [2:0]           in_command,
  input  logic                 in_limit_up,
  input  logic                 in_limit_down,
  input  logic [TIME_W-1:0]    in_now_ms,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [1:0]           out_gate_state,
  output logic                 out_motor_cut,
  output logic                 out_motor_brake,
  output logic [1:0]           out_drive_dir,
  output logic [DUTY_W-1:0]    out_drive_duty,
  output logic [1:0]           out_beep,
  output logic                 out_beep_stop,
  output logic                 out_locked_out
);

  // configuration
  logic [MS_W-1:0]   soft_start_r, travel_r, deadman_r, jog_max_r;
  logic [DUTY_W-1:0] duty_start_r, run_duty_r;

  // latched input word
  logic [2:0]        cmd_r;
  logic              up_r, down_r;
  logic [TIME_W-1:0] now_r;

  // gate state
  motion_state_t     dir_r, dir_nxt;
  logic              timed_r, timed_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] ka_r, ka_nxt;
  logic              seen_r, seen_nxt;
  logic              lock_r, lock_nxt;

  // per-word results
  logic              cut_r, cut_nxt;
  logic              brake_r, brake_nxt;
  logic [1:0]        beep_r, beep_nxt;
  logic              bstop_r, bstop_nxt;
  logic [1:0]        ddir_r, ddir_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              ramp_r, ramp_nxt;
  logic              fall_r, fall_nxt;
  logic [DUTY_W-1:0] delta_r, delta_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;

  // output register
  logic [1:0]        o_state_r, o_ddir_r, o_beep_r;
  logic              o_cut_r, o_brake_r, o_bstop_r, o_lock_r;
  logic [DUTY_W-1:0] o_duty_r;

  logic [TIME_W-1:0] ms_full;
  logic [TIME_W-1:0] ka_diff;
  logic              moving;
  logic              hit;
  logic [DIV_W-1:0]  prod;
  logic [DIV_W-1:0]  quotient;
  logic              div_done;

  assign moving  = (dir_r == ST_UP) || (dir_r == ST_DOWN);
  assign ms_full = now_r - start_r;
  assign ka_diff = now_r - ka_r;
  assign hit     = (dir_r == ST_UP) ? up_r : down_r;
  assign prod    = {{MS_W{1'b0}}, delta_r} * {{DUTY_W{1'b0}}, ms_r};

  gmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (soft_start_r),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    motion_state_t tdir;
    logic          ttimed;
    logic          done;
    dir_nxt   = dir_r;
    timed_nxt = timed_r;
    start_nxt = start_r;
    ka_nxt    = ka_r;
    seen_nxt  = seen_r;
    lock_nxt  = lock_r;
    cut_nxt   = cut_r;
    brake_nxt = brake_r;
    beep_nxt  = beep_r;
    bstop_nxt = bstop_r;
    ddir_nxt  = ddir_r;
    duty_nxt  = duty_r;
    ramp_nxt  = ramp_r;
    fall_nxt  = fall_r;
    delta_nxt = delta_r;
    ms_nxt    = ms_r;
    tdir      = (cmd_r == CMD_JOG_UP || cmd_r == CMD_OPEN) ? ST_UP : ST_DOWN;
    ttimed    = (cmd_r == CMD_OPEN || cmd_r == CMD_CLOSE);
    done      = 1'b0;

    if (cmd.do_cmd) begin
      cut_nxt   = 1'b0;
      brake_nxt = 1'b0;
      beep_nxt  = TONE_NONE;
      bstop_nxt = 1'b0;
      case (cmd_r)
        CMD_RESET: begin
          bstop_nxt = 1'b1;
          cut_nxt   = 1'b1;
          dir_nxt   = ST_IDLE;
        end
        CMD_STOP: begin
          lock_nxt = 1'b0;
          if (moving) begin
            brake_nxt = 1'b1;
            dir_nxt   = ST_IDLE;
          end
        end
        CMD_JOG_UP, CMD_JOG_DOWN, CMD_OPEN, CMD_CLOSE: begin
          if (dir_r != ST_TRIPPED) begin
            if (lock_r && (cmd_r inside {CMD_JOG_UP, CMD_JOG_DOWN})) begin
              ka_nxt = now_r;
            end else if (dir_r == tdir) begin
              ka_nxt = now_r;
              if (!ttimed) timed_nxt = 1'b0;
            end else begin
              if (moving) cut_nxt = 1'b1;
              timed_nxt = ttimed;
              start_nxt = now_r;
              ka_nxt    = now_r;
              seen_nxt  = (tdir == ST_UP) ? up_r : down_r;
              beep_nxt  = TONE_TICK;
              dir_nxt   = tdir;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.do_ctrl) begin
      if (lock_r && ka_diff > {{(TIME_W-MS_W){1'b0}}, deadman_r}) lock_nxt = 1'b0;
      ddir_nxt  = ST_IDLE;
      duty_nxt  = '0;
      ramp_nxt  = 1'b0;
      fall_nxt  = run_duty_r < duty_start_r;
      delta_nxt = (run_duty_r >= duty_start_r) ? run_duty_r - duty_start_r
                                               : duty_start_r - run_duty_r;
      ms_nxt    = ms_full[MS_W-1:0];
      if (moving) begin
        if (hit && !seen_r) begin
          brake_nxt = 1'b1;
          dir_nxt   = ST_IDLE;
          beep_nxt  = TONE_ARRIVE;
          done      = 1'b1;
        end else begin
          seen_nxt = hit;
          if (timed_r) begin
            if (ms_full >= {{(TIME_W-MS_W){1'b0}}, travel_r}) begin
              brake_nxt = 1'b1;
              dir_nxt   = ST_IDLE;
              done      = 1'b1;
            end
          end else if (ka_diff > {{(TIME_W-MS_W){1'b0}}, deadman_r}) begin
            brake_nxt = 1'b1;
            dir_nxt   = ST_IDLE;
            done      = 1'b1;
          end else if (ms_full >= {{(TIME_W-MS_W){1'b0}}, jog_max_r}) begin
            lock_nxt  = 1'b1;
            brake_nxt = 1'b1;
            dir_nxt   = ST_IDLE;
            beep_nxt  = TONE_PINCH;
            done      = 1'b1;
          end
        end
        if (!done) begin
          ddir_nxt = dir_r;
          if (ms_full < {{(TIME_W-MS_W){1'b0}}, soft_start_r}) begin
            ramp_nxt = 1'b1;
            duty_nxt = duty_start_r;
          end else begin
            duty_nxt = run_duty_r;
          end
        end
      end
    end else if (cmd.set_duty) begin
      duty_nxt = fall_r ? duty_start_r - quotient[DUTY_W-1:0]
                        : duty_start_r + quotient[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_start_r <= 16'd300;
      duty_start_r <= 8'd40;
      run_duty_r   <= 8'd100;
      travel_r     <= 16'd3000;
      deadman_r    <= 16'd300;
      jog_max_r    <= 16'd8000;
      dir_r        <= ST_IDLE;
      timed_r      <= 1'b0;
      start_r      <= '0;
      ka_r         <= '0;
      seen_r       <= 1'b0;
      lock_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOFT_START:   soft_start_r <= cfg_data;
          CFG_DUTY_START:   duty_start_r <= cfg_data[DUTY_W-1:0];
          CFG_DUTY_RUN:     run_duty_r   <= cfg_data[DUTY_W-1:0];
          CFG_TIMED_TRAVEL: travel_r     <= cfg_data;
          CFG_DEADMAN:      deadman_r    <= cfg_data;
          CFG_JOG_MAX:      jog_max_r    <= cfg_data;
          default: ;
        endcase
      end
      dir_r   <= dir_nxt;
      timed_r <= timed_nxt;
      start_r <= start_nxt;
      ka_r    <= ka_nxt;
      seen_r  <= seen_nxt;
      lock_r  <= lock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r  <= in_command;
      up_r   <= in_limit_up;
      down_r <= in_limit_down;
      now_r  <= in_now_ms;
    end
    cut_r   <= cut_nxt;
    brake_r <= brake_nxt;
    beep_r  <= beep_nxt;
    bstop_r <= bstop_nxt;
    ddir_r  <= ddir_nxt;
    duty_r  <= duty_nxt;
    ramp_r  <= ramp_nxt;
    fall_r  <= fall_nxt;
    delta_r <= delta_nxt;
    ms_r    <= ms_nxt;
    if (cmd.load_out) begin
      o_state_r <= dir_r;
      o_cut_r   <= cut_r;
      o_brake_r <= brake_r;
      o_ddir_r  <= ddir_r;
      o_duty_r  <= duty_r;
      o_beep_r  <= beep_r;
      o_bstop_r <= bstop_r;
      o_lock_r  <= lock_r;
    end
  end

  assign stat.ramp     = ramp_r;
  assign stat.div_done = div_done;

  assign out_gate_state  = o_state_r;
  assign out_motor_cut   = o_cut_r;
  assign out_motor_brake = o_brake_r;
  assign out_drive_dir   = o_ddir_r;
  assign out_drive_duty  = o_duty_r;
  assign out_beep        = o_beep_r;
  assign out_beep_stop   = o_bstop_r;
  assign out_locked_out  = o_lock_r;

endmodule

// File: sv/gmc_ctrl.sv
// gmc_ctrl: sequencer for one word: command, control step, ramp divide, output.
// Depends on gmc_pkg; drives gmc_dp through dp_cmd_t.
`timescale 1ns / 1ps

module gmc_ctrl
  import gmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMD;
      S_CMD:  state_nxt = S_CTRL;
      S_CTRL: state_nxt = S_RAMP;
      S_RAMP: state_nxt = stat.ramp ? S_DIV : S_OUT;
      S_DIV:  if (stat.div_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_CMD:  cmd.do_cmd    = 1'b1;
      S_CTRL: cmd.do_ctrl   = 1'b1;
      S_RAMP: cmd.div_start = stat.ramp;
      S_DIV:  cmd.set_duty  = stat.div_done;
      S_OUT:  cmd.load_out  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/gate_motion_controller.sv
// gate_motion_controller: top level of the barrier motor controller.
// Depends on gmc_pkg, gmc_ctrl and gmc_dp (which holds gmc_div).
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_command, in_limit_up, in_limit_down, in_now_ms
//   out      out_valid/out_ready  out_gate_state .. out_locked_out (one word per input)
//   cfg      cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// An accepted word passes the command, control and ramp steps, then a divide step when the
// drive is in soft start (the ramp duty comes from a 24-step restoring divider), then output.
// Reset is synchronous; only configuration, gate state and control registers are reset.
// A waiting result stalls only the load of the next result, not its acceptance.
`timescale 1ns / 1ps

module gate_motion_controller
  import gmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_command,
  input  logic                 in_limit_up,
  input  logic                 in_limit_down,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_gate_state,
  output logic                 out_motor_cut,
  output logic                 out_motor_brake,
  output logic [1:0]           out_drive_dir,
  output logic [DUTY_W-1:0]    out_drive_duty,
  output logic [1:0]           out_beep,
  output logic                 out_beep_stop,
  output logic                 out_locked_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gmc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_command),
    .in_limit_up     (in_limit_up),
    .in_limit_down   (in_limit_down),
    .in_now_ms       (in_now_ms),
    .cmd             (cmd),
    .stat            (stat),
    .out_gate_state  (out_gate_state),
    .out_motor_cut   (out_motor_cut),
    .out_motor_brake (out_motor_brake),
    .out_drive_dir   (out_drive_dir),
    .out_drive_duty  (out_drive_duty),
    .out_beep        (out_beep),
    .out_beep_stop   (out_beep_stop),
    .out_locked_out  (out_locked_out)
  );

endmodule

// File: tb/gate_motion_controller_test.sv
// gate_motion_controller_test: self-checking bench for the barrier motor controller.
// Directed table, then random phases across several register settings; needs gmc_pkg
// and the gate_motion_controller RTL only.
`timescale 1ns / 1ps

module gate_motion_controller_test
  import gmc_pkg::*;
();

  localparam logic [2:0] CMD_SPARE = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ROW_COUNT = 25;
  localparam int unsigned PHASE_COUNT = 9;
  localparam int unsigned PHASE_WORDS = 50;

  typedef struct packed {
    motion_state_t     gate_state;
    logic              motor_cut;
    logic              motor_brake;
    logic [1:0]        drive_dir;
    logic [DUTY_W-1:0] drive_duty;
    logic [1:0]        beep;
    logic              beep_stop;
    logic              locked_out;
  } gate_word_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic              up;
    logic              down;
    logic [TIME_W-1:0] now;
    logic              known;
    gate_word_t        word;
  } stim_row_t;

  localparam gate_word_t NO_WORD = '0;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SOFT_START;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_command = CMD_NONE;
  logic                 in_limit_up = 1'b0;
  logic                 in_limit_down = 1'b0;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_gate_state;
  logic                 out_motor_cut;
  logic                 out_motor_brake;
  logic [1:0]           out_drive_dir;
  logic [DUTY_W-1:0]    out_drive_duty;
  logic [1:0]           out_beep;
  logic                 out_beep_stop;
  logic                 out_locked_out;

  gate_motion_controller i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_limit_up     (in_limit_up),
    .in_limit_down   (in_limit_down),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_gate_state  (out_gate_state),
    .out_motor_cut   (out_motor_cut),
    .out_motor_brake (out_motor_brake),
    .out_drive_dir   (out_drive_dir),
    .out_drive_duty  (out_drive_duty),
    .out_beep        (out_beep),
    .out_beep_stop   (out_beep_stop),
    .out_locked_out  (out_locked_out)
  );

  // register copies
  logic [15:0] ramp_len = 16'd300;
  logic [7:0]  duty_start = 8'd40;
  logic [7:0]  run_duty = 8'd100;
  logic [15:0] travel_len = 16'd3000;
  logic [15:0] deadman_ms = 16'd300;
  logic [15:0] jog_limit = 16'd8000;

  // controller copy
  motion_state_t     dir_st = ST_IDLE;
  logic              timed_mv = 1'b0;
  logic [TIME_W-1:0] start_ms = '0;
  logic [TIME_W-1:0] alive_ms = '0;
  logic              lim_seen = 1'b0;
  logic              lockout = 1'b0;

  gate_word_t  pending_words[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic [TIME_W-1:0] t_now = '0;
  logic [2:0]        jog_cmd = CMD_JOG_UP;
  logic              lim_up_lvl = 1'b0;
  logic              lim_dn_lvl = 1'b0;
  int unsigned       step_span = 100;

  stim_row_t dir_rows [ROW_COUNT];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [DUTY_W-1:0] ramp_duty(input logic [TIME_W-1:0] ms);
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    lo = duty_start;
    hi = run_duty;
    span = ramp_len;
    if (ms >= TIME_W'(ramp_len)) return run_duty;
    if (hi >= lo) return DUTY_W'(lo + (hi - lo) * ms / span);
    return DUTY_W'(lo - (lo - hi) * ms / span);
  endfunction

  function automatic logic moving();
    return dir_st == ST_UP || dir_st == ST_DOWN;
  endfunction

  function automatic void brake_stop(inout gate_word_t w);
    if (moving()) begin
      w.motor_brake = 1'b1;
      dir_st = ST_IDLE;
    end
  endfunction

  function automatic void begin_move(input motion_state_t dir, input logic timed,
                                     input logic [TIME_W-1:0] now, input logic up,
                                     input logic down, inout gate_word_t w);
    if (dir_st == dir) begin
      alive_ms = now;
      if (!timed) timed_mv = 1'b0;
      return;
    end
    if (moving()) w.motor_cut = 1'b1;
    timed_mv = timed;
    start_ms = now;
    alive_ms = now;
    lim_seen = (dir == ST_UP) ? up : down;
    w.beep = TONE_TICK;
    dir_st = dir;
  endfunction

  function automatic gate_word_t predict_word(input logic [2:0] cmd, input logic up,
                                              input logic down,
                                              input logic [TIME_W-1:0] now);
    gate_word_t        w;
    logic [TIME_W-1:0] ms;
    logic [TIME_W-1:0] idle_for;
    logic              hit;
    logic              done;
    w = '0;
    if (cmd == CMD_RESET) begin
      w.beep_stop = 1'b1;
      w.motor_cut = 1'b1;
      dir_st = ST_IDLE;
    end else if (cmd == CMD_STOP) begin
      lockout = 1'b0;
      brake_stop(w);
    end else if (dir_st != ST_TRIPPED) begin
      if (lockout && (cmd == CMD_JOG_UP || cmd == CMD_JOG_DOWN)) begin
        alive_ms = now;
      end else begin
        case (cmd)
          CMD_JOG_UP:   begin_move(ST_UP, 1'b0, now, up, down, w);
          CMD_JOG_DOWN: begin_move(ST_DOWN, 1'b0, now, up, down, w);
          CMD_OPEN:     begin_move(ST_UP, 1'b1, now, up, down, w);
          CMD_CLOSE:    begin_move(ST_DOWN, 1'b1, now, up, down, w);
          default: ;
        endcase
      end
    end
    idle_for = now - alive_ms;
    if (lockout && idle_for > TIME_W'(deadman_ms)) lockout = 1'b0;
    if (moving()) begin
      ms = now - start_ms;
      hit = (dir_st == ST_UP) ? up : down;
      done = 1'b0;
      if (hit && !lim_seen) begin
        brake_stop(w);
        w.beep = TONE_ARRIVE;
        done = 1'b1;
      end else begin
        lim_seen = hit;
        if (timed_mv) begin
          if (ms >= TIME_W'(travel_len)) begin
            brake_stop(w);
            done = 1'b1;
          end
        end else if (idle_for > TIME_W'(deadman_ms)) begin
          brake_stop(w);
          done = 1'b1;
        end else if (ms >= TIME_W'(jog_limit)) begin
          lockout = 1'b1;
          brake_stop(w);
          w.beep = TONE_PINCH;
          done = 1'b1;
        end
      end
      if (!done) begin
        w.drive_dir = dir_st;
        w.drive_duty = ramp_duty(ms);
      end
    end
    w.gate_state = dir_st;
    w.locked_out = lockout;
    return w;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t   row;
    int unsigned pick;
    row = '0;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
    end else if (pick < 70) begin
      t_now += $urandom_range(1, step_span);
    end else if (pick < 92) begin
      t_now += $urandom_range(step_span, 4 * step_span);
    end else if (pick < 97) begin
      t_now += $urandom_range(0, 70000);
    end else begin
      t_now = $urandom();
    end
    if ($urandom_range(0, 99) < 8) lim_up_lvl = !lim_up_lvl;
    if ($urandom_range(0, 99) < 8) lim_dn_lvl = !lim_dn_lvl;
    pick = $urandom_range(0, 99);
    if (pick < 30) row.cmd = CMD_NONE;
    else if (pick < 50) row.cmd = jog_cmd;
    else if (pick < 58) begin
      jog_cmd = (jog_cmd == CMD_JOG_UP) ? CMD_JOG_DOWN : CMD_JOG_UP;
      row.cmd = jog_cmd;
    end
    else if (pick < 68) row.cmd = CMD_OPEN;
    else if (pick < 78) row.cmd = CMD_CLOSE;
    else if (pick < 88) row.cmd = CMD_STOP;
    else if (pick < 94) row.cmd = CMD_RESET;
    else if (pick < 97) row.cmd = CMD_SPARE;
    else row.cmd = 3'($urandom_range(0, 7));
    row.up = lim_up_lvl;
    row.down = lim_dn_lvl;
    row.now = t_now;
    return row;
  endfunction

  task automatic push_word(input stim_row_t row);
    gate_word_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= row.cmd;
    in_limit_up <= row.up;
    in_limit_down <= row.down;
    in_now_ms <= row.now;
    do @(posedge clk); while (!in_ready);
    want = predict_word(row.cmd, row.up, row.down, row.now);
    pending_words.push_back(row.known ? row.word : want);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SOFT_START:   ramp_len = val;
      CFG_DUTY_START:   duty_start = val[7:0];
      CFG_DUTY_RUN:     run_duty = val[7:0];
      CFG_TIMED_TRAVEL: travel_len = val;
      CFG_DEADMAN:      deadman_ms = val;
      CFG_JOG_MAX:      jog_limit = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk) out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin : check_words
    gate_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("gate_state", want.gate_state, out_gate_state);
        check_field("motor_cut", want.motor_cut, out_motor_cut);
        check_field("motor_brake", want.motor_brake, out_motor_brake);
        check_field("drive_dir", want.drive_dir, out_drive_dir);
        check_field("drive_duty", want.drive_duty, out_drive_duty);
        check_field("beep", want.beep, out_beep);
        check_field("beep_stop", want.beep_stop, out_beep_stop);
        check_field("locked_out", want.locked_out, out_locked_out);
      end
    end
  end

  initial begin
    dir_rows[0]  = '{CMD_RESET, 1'b0, 1'b0, 32'd0, 1'b1,
                     '{ST_IDLE, 1'b1, 1'b0, 2'd0, 8'd0, TONE_NONE, 1'b1, 1'b0}};
    dir_rows[1]  = '{CMD_NONE, 1'b0, 1'b0, 32'd5, 1'b1, NO_WORD};
    dir_rows[2]  = '{CMD_OPEN, 1'b0, 1'b0, 32'd100, 1'b1,
                     '{ST_UP, 1'b0, 1'b0, ST_UP, 8'd40, TONE_TICK, 1'b0, 1'b0}};
    dir_rows[3]  = '{CMD_NONE, 1'b0, 1'b0, 32'd250, 1'b0, NO_WORD};
    dir_rows[4]  = '{CMD_NONE, 1'b0, 1'b0, 32'd400, 1'b0, NO_WORD};
    dir_rows[5]  = '{CMD_NONE, 1'b1, 1'b0, 32'd500, 1'b1,
                     '{ST_IDLE, 1'b0, 1'b1, 2'd0, 8'd0, TONE_ARRIVE, 1'b0, 1'b0}};
    dir_rows[6]  = '{CMD_CLOSE, 1'b0, 1'b1, 32'd600, 1'b0, NO_WORD};
    dir_rows[7]  = '{CMD_NONE, 1'b0, 1'b0, 32'd700, 1'b0, NO_WORD};
    dir_rows[8]  = '{CMD_JOG_UP, 1'b0, 1'b0, 32'd800, 1'b0, NO_WORD};
    dir_rows[9]  = '{CMD_OPEN, 1'b0, 1'b0, 32'd950, 1'b0, NO_WORD};
    dir_rows[10] = '{CMD_NONE, 1'b0, 1'b0, 32'd1300, 1'b0, NO_WORD};
    dir_rows[11] = '{CMD_JOG_DOWN, 1'b0, 1'b0, 32'd2000, 1'b0, NO_WORD};
    dir_rows[12] = '{CMD_JOG_DOWN, 1'b0, 1'b0, 32'd2250, 1'b0, NO_WORD};
    dir_rows[13] = '{CMD_JOG_DOWN, 1'b0, 1'b0, 32'd2500, 1'b0, NO_WORD};
    dir_rows[14] = '{CMD_JOG_DOWN, 1'b0, 1'b0, 32'd2750, 1'b0, NO_WORD};
    dir_rows[15] = '{CMD_JOG_DOWN, 1'b0, 1'b0, 32'd3000, 1'b1,
                     '{ST_IDLE, 1'b0, 1'b1, 2'd0, 8'd0, TONE_PINCH, 1'b0, 1'b1}};
    dir_rows[16] = '{CMD_JOG_UP, 1'b0, 1'b0, 32'd3100, 1'b0, NO_WORD};
    dir_rows[17] = '{CMD_NONE, 1'b0, 1'b0, 32'd3500, 1'b0, NO_WORD};
    dir_rows[18] = '{CMD_OPEN, 1'b0, 1'b0, 32'd3600, 1'b0, NO_WORD};
    dir_rows[19] = '{CMD_STOP, 1'b0, 1'b0, 32'd3700, 1'b0, NO_WORD};
    dir_rows[20] = '{CMD_STOP, 1'b0, 1'b0, 32'd3800, 1'b1, NO_WORD};
    dir_rows[21] = '{CMD_CLOSE, 1'b0, 1'b0, 32'hFFFF_FF00, 1'b0, NO_WORD};
    dir_rows[22] = '{CMD_SPARE, 1'b0, 1'b0, 32'h0000_0010, 1'b0, NO_WORD};
    dir_rows[23] = '{CMD_RESET, 1'b0, 1'b0, 32'h0000_0020, 1'b0, NO_WORD};
    dir_rows[24] = '{CMD_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, NO_WORD};
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // shorten the jog limit so the lockout shows up in the table
    write_reg(CFG_JOG_MAX, 16'd1000);
    cfg_we <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 63;
    for (int i = 0; i < ROW_COUNT; i++) push_word(dir_rows[i]);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      case (p / 3)
        0: begin send_idle_pct = 11; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        1: begin
          write_reg(CFG_SOFT_START, 16'd0);
          write_reg(CFG_DUTY_START, 16'd255);
          write_reg(CFG_DUTY_RUN, 16'd0);
          write_reg(CFG_TIMED_TRAVEL, 16'd0);
          write_reg(CFG_DEADMAN, 16'd0);
          write_reg(CFG_JOG_MAX, 16'd0);
        end
        4: begin
          write_reg(CFG_SOFT_START, 16'hFFFF);
          write_reg(CFG_DUTY_START, 16'd0);
          write_reg(CFG_DUTY_RUN, 16'd255);
          write_reg(CFG_TIMED_TRAVEL, 16'hFFFF);
          write_reg(CFG_DEADMAN, 16'hFFFF);
          write_reg(CFG_JOG_MAX, 16'hFFFF);
        end
        7: begin
          write_reg(CFG_SOFT_START, 16'd1);
          write_reg(CFG_DUTY_START, 16'd0);
          write_reg(CFG_DUTY_RUN, 16'd255);
          write_reg(CFG_TIMED_TRAVEL, 16'd1);
          write_reg(CFG_DEADMAN, 16'd1);
          write_reg(CFG_JOG_MAX, 16'd1);
        end
        default: begin
          write_reg(CFG_SOFT_START, 16'($urandom_range(1, 600)));
          write_reg(CFG_DUTY_START, 16'($urandom_range(0, 255)));
          write_reg(CFG_DUTY_RUN, 16'($urandom_range(0, 255)));
          write_reg(CFG_TIMED_TRAVEL, 16'($urandom_range(50, 3000)));
          write_reg(CFG_DEADMAN, 16'($urandom_range(50, 800)));
          write_reg(CFG_JOG_MAX, 16'($urandom_range(100, 3000)));
        end
      endcase
      cfg_we <= 1'b0;
      step_span = $urandom_range(20, 400);
      // start some phases just short of the timestamp wrap
      if ($urandom_range(0, 2) == 0) t_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      for (int n = 0; n < PHASE_WORDS; n++) push_word(random_row());
    end

    settle();
    if (mismatch_count == 0 && pending_words.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/gmc_pkg.sv
sv/gmc_div.sv
sv/gmc_dp.sv
sv/gmc_ctrl.sv
sv/gate_motion_controller.sv
tb/gate_motion_controller_test.sv
